// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the histogram RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable
`define ABIH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold
`define ABIH_NEVER(lbl, clk, rst_n, expr, msg) \
    `ABIH_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// File: hw/rtl/abih_pkg.sv
// Shared types and constants of the angle-binned histogram.
// Used by every module of the block except abih_ram; depends on nothing.
package abih_pkg;

    localparam int NUM_BINS_DEF = 1024;

    localparam int SUM_W  = 48;
    localparam int CNT_W  = 24;
    localparam int WORD_W = SUM_W + CNT_W;
    localparam int ANG_W  = 24;
    localparam int INT_W  = 32;
    localparam int CORR_W = 16;
    localparam int INTC_W = 36;
    localparam int RBIN_W = 10;
    localparam int BINS_W = 11;
    localparam int CFG_W  = 24;
    localparam int CFG_A_W = 3;

    // shared serial multiplier and divider sizes
    localparam int MUL_A_W = 56;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam int DIV_S_W = $clog2(DIV_N_W + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [CFG_A_W-1:0] CFG_MIN_TTH   = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_BIN_WIDTH = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_BINS      = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_AVG_MODE  = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_AVG_SCALE = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_NORM      = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_USE_CORR  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_DIV,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_RD,
        ST_RD_DATA,
        ST_RD_AVGMUL,
        ST_RD_AVGDIV,
        ST_RD_NORM,
        ST_RD_PUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_st_t;

endpackage

// File: hw/rtl/abih_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// Holds the bin sums and hit counts; no package dependencies.
module abih_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/abih_smul.sv
// Shift-add serial multiplier, one multiplier bit per cycle.
// Depends on abih_pkg for the status struct.
module abih_smul #(
    parameter int A_W = abih_pkg::MUL_A_W,
    parameter int B_W = abih_pkg::MUL_B_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [A_W-1:0]        a,
    input  logic [B_W-1:0]        b,
    output abih_pkg::unit_st_t    st,
    output logic [A_W+B_W-1:0]    prod
);
    import abih_pkg::*;

    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(B_W + 1);

    logic [P_W-1:0] a_sh_reg, a_sh_next;
    logic [P_W-1:0] acc_reg, acc_next;
    logic [B_W-1:0] b_reg, b_next;
    logic [C_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    always_comb begin
        a_sh_next = a_sh_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_sh_next = P_W'(a);
            acc_next  = '0;
            b_next    = b;
            cnt_next  = C_W'(B_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_sh_reg;
            end
            a_sh_next = {a_sh_reg[P_W-2:0], 1'b0};
            b_next    = b_reg >> 1;
            cnt_next  = cnt_reg - C_W'(1);
            if (cnt_reg == C_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_sh_reg <= a_sh_next;
        acc_reg  <= acc_next;
        b_reg    <= b_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;
    assign prod    = acc_reg;
endmodule

// File: hw/rtl/abih_div.sv
// Restoring divider, one quotient bit per cycle, step count set per request.
// Depends on abih_pkg and assert_macros.svh.
`include "assert_macros.svh"
module abih_div #(
    parameter int N_W = abih_pkg::DIV_N_W,
    parameter int D_W = abih_pkg::DIV_D_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [N_W-1:0]             num,
    input  logic [D_W-1:0]             den,
    input  logic [$clog2(N_W+1)-1:0]   steps,
    output abih_pkg::unit_st_t         st,
    output logic [N_W-1:0]             quot
);
    import abih_pkg::*;

    localparam int S_W = $clog2(N_W + 1);

    logic [N_W-1:0] num_reg, num_next;
    logic [N_W-1:0] quot_reg, quot_next;
    logic [D_W:0]   rem_reg, rem_next;
    logic [D_W-1:0] den_reg, den_next;
    logic [S_W-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [D_W:0]   rem_sh;
    logic           ge;

    assign rem_sh = {rem_reg[D_W-1:0], num_reg[N_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            quot_next = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next  = {num_reg[N_W-2:0], 1'b0};
            quot_next = {quot_reg[N_W-2:0], ge};
            rem_next  = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            cnt_next  = cnt_reg - S_W'(1);
            if (cnt_reg == S_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;
    assign quot    = quot_reg;

    `ABIH_ASSERT(a_div_start_idle, aclk, aresetn, start |-> !busy_reg, "divider restarted while busy")
    `ABIH_ASSERT(a_div_done_end, aclk, aresetn, done_reg |-> $past(busy_reg), "divider done without run")
endmodule

// File: hw/rtl/angle_binned_intensity_histogram_core.sv
// Angle-binned intensity histogram: one request at a time, state held in a single
// bin RAM (sum and hit count per bin). An accumulate runs the 24-step bin-index
// divider, then reads and writes back the bin word. A read runs a 24-step serial
// norm multiply in sum mode; in average mode with hits it runs a 24-step scale
// multiply, a 64-step divide and a 24-step norm multiply. It may then wait on
// m_tready. A clear, and the sweep after reset, zero all NUM_BINS bin words with
// s_tready low.
`include "assert_macros.svh"
module angle_binned_intensity_histogram_core #(
    parameter int NUM_BINS = abih_pkg::NUM_BINS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [abih_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [abih_pkg::CFG_W-1:0]    cfg_wdata,
    // requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // intensity[31:0], correction[47:32], two_theta[71:48], read_bin[81:72]
    input  logic [87:0]                   s_tdata,
    // opcode[1:0], intensity_invalid[2], correction_invalid[3]
    input  logic [3:0]                    s_tuser,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bin_number[9:0], bin_angle[41:10], bin_value[89:42], bin_hits[113:90]
    output logic [119:0]                  m_tdata
);
    import abih_pkg::*;

    localparam int IDX_W  = $clog2(NUM_BINS);
    localparam int CMP_W  = (IDX_W + 1 > BINS_W) ? IDX_W + 1 : BINS_W;
    localparam int AFUL_W = ANG_W + IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

    // configuration registers
    logic [ANG_W-1:0]  min_tth_reg;
    logic [ANG_W-1:0]  bin_width_reg;
    logic [BINS_W-1:0] bins_reg;
    logic              avg_mode_reg;
    logic [15:0]       avg_scale_reg;
    logic [23:0]       norm_reg;
    logic              use_corr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_tth_reg   <= '0;
            bin_width_reg <= 24'd65536;
            bins_reg      <= 11'd1024;
            avg_mode_reg  <= 1'b0;
            avg_scale_reg <= 16'd256;
            norm_reg      <= 24'd65536;
            use_corr_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MIN_TTH:   min_tth_reg   <= cfg_wdata;
                CFG_BIN_WIDTH: bin_width_reg <= cfg_wdata;
                CFG_BINS:      bins_reg      <= cfg_wdata[BINS_W-1:0];
                CFG_AVG_MODE:  avg_mode_reg  <= cfg_wdata[0];
                CFG_AVG_SCALE: avg_scale_reg <= cfg_wdata[15:0];
                CFG_NORM:      norm_reg      <= cfg_wdata;
                CFG_USE_CORR:  use_corr_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // request fields
    logic signed [INT_W-1:0] in_int;
    logic [CORR_W-1:0]       in_corr;
    logic [ANG_W-1:0]        in_tth;
    logic [RBIN_W-1:0]       in_rbin;
    opcode_t                 in_op;
    logic                    in_int_bad, in_corr_bad;

    assign in_int      = s_tdata[31:0];
    assign in_corr     = s_tdata[47:32];
    assign in_tth      = s_tdata[71:48];
    assign in_rbin     = s_tdata[81:72];
    assign in_op       = opcode_t'(s_tuser[1:0]);
    assign in_int_bad  = s_tuser[2];
    assign in_corr_bad = s_tuser[3];

    state_t state_reg, state_next;
    logic   accept;
    logic   drop_pixel;

    assign accept     = s_tvalid && s_tready;
    assign drop_pixel = in_int_bad || (use_corr_reg && in_corr_bad);

    // payload registers
    logic signed [INT_W-1:0]  int_reg;
    logic [CORR_W-1:0]        corr_reg;
    logic [ANG_W-1:0]         tth_reg;
    logic signed [INTC_W-1:0] inten_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         clr_cnt_reg;
    logic [31:0]              angle_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic signed [SUM_W-1:0]  val_reg;
    logic [119:0]             out_data_reg;
    logic                     m_tvalid_reg;

    // memory and shared units
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;
    logic                mul_start, div_start;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_prod;
    logic [DIV_N_W-1:0]  div_num, div_quot;
    logic [DIV_D_W-1:0]  div_den;
    logic [DIV_S_W-1:0]  div_steps;
    unit_st_t            mul_st, div_st;
    logic                out_load;

    abih_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BINS)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    abih_smul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a), .b(mul_b),
        .st(mul_st), .prod(mul_prod)
    );

    abih_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num), .den(div_den),
        .steps(div_steps), .st(div_st), .quot(div_quot)
    );

    // last bin in use
    logic [CMP_W-1:0] bins_ext;
    logic [IDX_W-1:0] nb_last;
    assign bins_ext = CMP_W'(bins_reg);
    always_comb begin
        if (bins_ext == '0) begin
            nb_last = '0;
        end else if (bins_ext > CMP_W'(NUM_BINS)) begin
            nb_last = LAST_IDX;
        end else begin
            nb_last = IDX_W'(bins_ext - CMP_W'(1));
        end
    end

    // bin index from divider quotient
    logic [IDX_W-1:0] acc_idx;
    logic [ANG_W-1:0] quo24;
    assign quo24 = div_quot[ANG_W-1:0];
    always_comb begin
        if (tth_reg < min_tth_reg) begin
            acc_idx = '0;
        end else if (bin_width_reg == '0) begin
            acc_idx = nb_last;
        end else if (quo24 > ANG_W'(nb_last)) begin
            acc_idx = nb_last;
        end else begin
            acc_idx = IDX_W'(quo24);
        end
    end

    // read index clamp
    logic [CMP_W-1:0] rbin_ext;
    logic [IDX_W-1:0] rd_idx;
    assign rbin_ext = CMP_W'(in_rbin);
    assign rd_idx   = (rbin_ext >= CMP_W'(NUM_BINS)) ? LAST_IDX : IDX_W'(rbin_ext);

    // corrected intensity
    logic signed [48:0] cprod;
    assign cprod = int_reg * $signed({1'b0, corr_reg});

    // bin word fields and saturating update
    logic signed [SUM_W-1:0] ram_sum;
    logic [CNT_W-1:0]        ram_cnt;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic [CNT_W-1:0]        cnt_inc;
    logic [SUM_W-1:0]        ram_mag;

    assign ram_sum  = ram_rdata[SUM_W-1:0];
    assign ram_cnt  = ram_rdata[WORD_W-1:SUM_W];
    assign sum_wide = (SUM_W+1)'(ram_sum) + (SUM_W+1)'(inten_reg);
    always_comb begin
        if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
            sum_sat = SUM_MAX;
        end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end
    assign cnt_inc = (ram_cnt == CNT_MAX) ? ram_cnt : ram_cnt + CNT_W'(1);
    assign ram_mag = ram_sum[SUM_W-1] ? SUM_W'(-ram_sum) : SUM_W'(ram_sum);

    // bin angle
    logic [AFUL_W-1:0] ang_full;
    assign ang_full = AFUL_W'(min_tth_reg) + AFUL_W'(bin_width_reg) * AFUL_W'(idx_reg);

    // final normalized value
    logic [63:0]             norm_r;
    logic signed [SUM_W-1:0] val_fin;
    assign norm_r = mul_prod[MUL_P_W-1:16];
    always_comb begin
        if (!neg_reg) begin
            val_fin = (norm_r > 64'(SUM_MAX)) ? SUM_MAX : norm_r[SUM_W-1:0];
        end else if (norm_r > 64'(SUM_MAX) + 64'd1) begin
            val_fin = SUM_MIN;
        end else begin
            val_fin = -$signed(norm_r[SUM_W-1:0]);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_IDX) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_ACCUM: state_next = drop_pixel ? ST_IDLE : ST_ACC_MUL;
                        OP_READ:  state_next = ST_RD_RD;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC_MUL:   state_next = ST_ACC_DIV;
            ST_ACC_DIV: begin
                if (div_st.done) state_next = ST_ACC_RD;
            end
            ST_ACC_RD:    state_next = ST_ACC_WR;
            ST_ACC_WR:    state_next = ST_IDLE;
            ST_RD_RD:     state_next = ST_RD_DATA;
            ST_RD_DATA: begin
                state_next = (avg_mode_reg && ram_cnt != '0) ? ST_RD_AVGMUL : ST_RD_NORM;
            end
            ST_RD_AVGMUL: begin
                if (mul_st.done) state_next = ST_RD_AVGDIV;
            end
            ST_RD_AVGDIV: begin
                if (div_st.done) state_next = ST_RD_NORM;
            end
            ST_RD_NORM: begin
                if (mul_st.done) state_next = ST_RD_PUT;
            end
            ST_RD_PUT: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {cnt_inc, sum_sat};
        ram_raddr = idx_reg;
        mul_start = 1'b0;
        mul_a     = MUL_A_W'(ram_mag);
        mul_b     = norm_reg;
        div_start = 1'b0;
        div_num   = {tth_reg - min_tth_reg, 40'd0};
        div_den   = DIV_D_W'(bin_width_reg);
        div_steps = DIV_S_W'(ANG_W);
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:    s_tready = 1'b1;
            ST_ACC_MUL: div_start = 1'b1;
            ST_ACC_WR:  ram_we = 1'b1;
            ST_RD_DATA: begin
                mul_start = 1'b1;
                if (avg_mode_reg && ram_cnt != '0) begin
                    mul_b = MUL_B_W'(avg_scale_reg);
                end
            end
            ST_RD_AVGMUL: begin
                if (mul_st.done) begin
                    div_start = 1'b1;
                    div_num   = mul_prod[DIV_N_W-1:0];
                    div_den   = {cnt_reg, 8'd0};
                    div_steps = DIV_S_W'(DIV_N_W);
                end
            end
            ST_RD_AVGDIV: begin
                if (div_st.done) begin
                    mul_start = 1'b1;
                    mul_a     = div_quot[MUL_A_W-1:0];
                end
            end
            ST_RD_PUT:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end else if (accept && in_op == OP_CLEAR) begin
                clr_cnt_reg <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            int_reg  <= in_int;
            corr_reg <= in_corr;
            tth_reg  <= in_tth;
            idx_reg  <= rd_idx;
        end
        if (state_reg == ST_ACC_MUL) begin
            inten_reg <= use_corr_reg ? cprod[47:12] : INTC_W'(int_reg);
        end
        if (state_reg == ST_ACC_DIV && div_st.done) begin
            idx_reg <= acc_idx;
        end
        if (state_reg == ST_RD_RD) begin
            angle_reg <= (64'(ang_full) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(ang_full);
        end
        if (state_reg == ST_RD_DATA) begin
            cnt_reg <= ram_cnt;
            neg_reg <= ram_sum[SUM_W-1];
        end
        if (state_reg == ST_RD_NORM && mul_st.done) begin
            val_reg <= val_fin;
        end
        if (out_load) begin
            out_data_reg <= {6'd0, cnt_reg, val_reg, angle_reg, RBIN_W'(idx_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    `ABIH_ASSERT(a_out_no_overwrite, aclk, aresetn, out_load |-> (!m_tvalid_reg || m_tready), "result overwritten")
    `ABIH_NEVER(a_units_exclusive, aclk, aresetn, mul_st.busy && div_st.busy, "multiplier and divider both busy")
    `ABIH_ASSERT(a_clear_starts, aclk, aresetn, (accept && in_op == OP_CLEAR) |=> (state_reg == ST_CLEAR), "clear request did not start sweep")
endmodule
